>>> src/u8cm_pkg.sv
package u8cm_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } u8cm_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } u8cm_out_t;

  // Longest UTF-8 form of one map code: a 4-byte code point plus the selector.
  localparam int unsigned ENC_BYTES = 7;

  typedef struct packed {
    logic [2:0]                len;
    logic [ENC_BYTES-1:0][7:0] b;
  } u8cm_enc_t;

  typedef struct packed {
    logic [2:0]      len;
    logic [3:0][7:0] b;
  } u8cm_cp_t;

  localparam logic [17:0] VS16 = 18'h0fe0f;

  // Bit 18 marks an entry that is followed by the selector.
  localparam logic [18:0] LOW_MAP [32] = '{
    19'h00000, 19'h000B9, 19'h000B2, 19'h000B3, 19'h02074, 19'h02075, 19'h02076, 19'h02077,
    19'h02078, 19'h00009, 19'h0000A, 19'h01D47, 19'h01D9C, 19'h0000D, 19'h01D49, 19'h01DA0,
    19'h025AE, 19'h025A0, 19'h025A1, 19'h02059, 19'h02058, 19'h02016, 19'h025C0, 19'h025B6,
    19'h0300C, 19'h0300D, 19'h000A5, 19'h02022, 19'h03001, 19'h03002, 19'h0309B, 19'h0309C
  };

  localparam logic [18:0] HIGH_MAP [129] = '{
    19'h025CB,
    19'h02588, 19'h02592, 19'h1F431, 19'h42B07, 19'h02591, 19'h0273D, 19'h025CF, 19'h02665,
    19'h02609, 19'h0C6C3, 19'h02302, 19'h42B05, 19'h1F610, 19'h0266A, 19'h5F17E, 19'h025C6,
    19'h02026, 19'h427A1, 19'h02605, 19'h029D7, 19'h42B06, 19'h002C7, 19'h02227, 19'h0274E,
    19'h025A4, 19'h025A5, 19'h03042, 19'h03044, 19'h03046, 19'h03048, 19'h0304A, 19'h0304B,
    19'h0304D, 19'h0304F, 19'h03051, 19'h03053, 19'h03055, 19'h03057, 19'h03059, 19'h0305B,
    19'h0305D, 19'h0305F, 19'h03061, 19'h03064, 19'h03066, 19'h03068, 19'h0306A, 19'h0306B,
    19'h0306C, 19'h0306D, 19'h0306E, 19'h0306F, 19'h03072, 19'h03075, 19'h03078, 19'h0307B,
    19'h0307E, 19'h0307F, 19'h03080, 19'h03081, 19'h03082, 19'h03084, 19'h03086, 19'h03088,
    19'h03089, 19'h0308A, 19'h0308B, 19'h0308C, 19'h0308D, 19'h0308F, 19'h03092, 19'h03093,
    19'h03063, 19'h03083, 19'h03085, 19'h03087, 19'h030A2, 19'h030A4, 19'h030A6, 19'h030A8,
    19'h030AA, 19'h030AB, 19'h030AD, 19'h030AF, 19'h030B1, 19'h030B3, 19'h030B5, 19'h030B7,
    19'h030B9, 19'h030BB, 19'h030BD, 19'h030BF, 19'h030C1, 19'h030C4, 19'h030C6, 19'h030C8,
    19'h030CA, 19'h030CB, 19'h030CC, 19'h030CD, 19'h030CE, 19'h030CF, 19'h030D2, 19'h030D5,
    19'h030D8, 19'h030DB, 19'h030DE, 19'h030DF, 19'h030E0, 19'h030E1, 19'h030E2, 19'h030E4,
    19'h030E6, 19'h030E8, 19'h030E9, 19'h030EA, 19'h030EB, 19'h030EC, 19'h030ED, 19'h030EF,
    19'h030F2, 19'h030F3, 19'h030C3, 19'h030E3, 19'h030E5, 19'h030E7, 19'h025DC, 19'h025DD
  };

  function automatic u8cm_cp_t u8cm_put_cp(input logic [17:0] cp);
    u8cm_cp_t r;
    r = '0;
    if (cp < 18'h80) begin
      r.len  = 3'd1;
      r.b[0] = cp[7:0];
    end else if (cp < 18'h800) begin
      r.len  = 3'd2;
      r.b[0] = {3'b110, cp[10:6]};
      r.b[1] = {2'b10, cp[5:0]};
    end else if (cp < 18'h10000) begin
      r.len  = 3'd3;
      r.b[0] = {4'b1110, cp[15:12]};
      r.b[1] = {2'b10, cp[11:6]};
      r.b[2] = {2'b10, cp[5:0]};
    end else begin
      // The code points in the map stay below bit 18, so the lead byte is 0xF0.
      r.len  = 3'd4;
      r.b[0] = {5'b11110, 3'b000};
      r.b[1] = {2'b10, cp[17:12] & 6'h3f};
      r.b[2] = {2'b10, cp[11:6]};
      r.b[3] = {2'b10, cp[5:0]};
    end
    return r;
  endfunction

  // UTF-8 form of one map code.
  function automatic u8cm_enc_t u8cm_encode(input logic [7:0] c);
    logic [18:0] e;
    u8cm_cp_t    p;
    u8cm_cp_t    v;
    u8cm_enc_t   r;
    if (c < 8'd32) begin
      e = LOW_MAP[c[4:0]];
    end else if (c < 8'h7f) begin
      e = {11'd0, c};
    end else begin
      e = HIGH_MAP[8'(c - 8'h7f)];
    end
    p = u8cm_put_cp(e[17:0]);
    v = u8cm_put_cp(VS16);
    r = '0;
    r.len = p.len;
    for (int i = 0; i < 4; i++) begin
      r.b[i] = p.b[i];
    end
    if (e[18]) begin
      for (int i = 0; i < int'(ENC_BYTES); i++) begin
        for (int k = 0; k < 3; k++) begin
          if (i == int'(p.len) + k) begin
            r.b[i] = v.b[k];
          end
        end
      end
      r.len = 3'(p.len + 3'd3);
    end
    return r;
  endfunction

endpackage

>>> src/utf8_charmap_transcoder.sv
// Channel | Direction | Handshake             | Word
// in      | input     | in_valid_i/in_ready_o | u8cm_in_t: in_byte, in_last
// out     | output    | out_valid_o/out_ready_i | u8cm_out_t: out_byte, out_last
// cfg     | input     | cfg_we_i (no wait)    | cfg_wdata_i: direction
// Encode accepts a word, then sends its UTF-8 form out byte by byte (1 to 7 bytes).
// Decode sweeps the 256-entry code table one entry a cycle through a single
// compare unit; a pass ends at a full match or after the last entry.
// A word may need several passes when held bytes are rescanned after a mismatch.
// Reset clears the sequencer, the held-byte count, the direction and the output valid flag.
// A stalled output holds the sequencer until the output register frees up.
module utf8_charmap_transcoder #(
  parameter int unsigned MaxSeqBytes = 7
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  u8cm_pkg::u8cm_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output u8cm_pkg::u8cm_out_t out_data_o,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i
);
  import u8cm_pkg::*;

  localparam int unsigned CntW = $clog2(MaxSeqBytes + 1);
  localparam int unsigned IdxW = $clog2(MaxSeqBytes);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StEnc  = 2'd1;
  localparam logic [1:0] StScan = 2'd2;
  localparam logic [1:0] StEmit = 2'd3;

  logic [1:0]      state_q, state_d;
  logic            dir_q;
  logic            last_q, last_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]      buf_q [MaxSeqBytes];
  logic [7:0]      buf_d [MaxSeqBytes];
  logic [7:0]      code_q, code_d;
  logic            part_q, part_d;
  logic [7:0]      emit_q, emit_d;
  logic [2:0]      shift_q, shift_d;
  u8cm_enc_t       enc_q, enc_d;
  logic [2:0]      idx_q, idx_d;
  logic            ovalid_q, ovalid_d;
  u8cm_out_t       odata_q, odata_d;

  logic            in_acc, out_free;
  u8cm_enc_t       ent;
  logic            full_hit, part_hit, fl_ok, pl_ok;
  logic [CntW-1:0] cnt_rem;

  assign in_ready_o  = (state_q == StIdle);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !ovalid_q || out_ready_i;
  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;

  // Shared compare unit: one table entry against the held bytes each cycle.
  assign ent = u8cm_encode(code_q);
  always_comb begin
    fl_ok = 1'b1;
    pl_ok = 1'b1;
    for (int i = 0; i < int'(MaxSeqBytes); i++) begin
      if (i < int'(ENC_BYTES)) begin
        if (ent.b[i] != buf_q[i]) begin
          if (i < int'(ent.len)) fl_ok = 1'b0;
          if (i < int'(cnt_q))   pl_ok = 1'b0;
        end
      end else if (i < int'(cnt_q)) begin
        pl_ok = 1'b0;
      end
    end
    full_hit = (ent.len >= 3'd2) && (CntW'(ent.len) <= cnt_q) && fl_ok;
    part_hit = (ent.len >= 3'd2) && (CntW'(ent.len) > cnt_q) && pl_ok;
  end

  assign cnt_rem = cnt_q - CntW'(shift_q);

  always_comb begin
    state_d  = state_q;
    last_d   = last_q;
    cnt_d    = cnt_q;
    buf_d    = buf_q;
    code_d   = code_q;
    part_d   = part_q;
    emit_d   = emit_q;
    shift_d  = shift_q;
    enc_d    = enc_q;
    idx_d    = idx_q;
    ovalid_d = ovalid_q && !out_ready_i;
    odata_d  = odata_q;

    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          last_d = in_data_i.in_last;
          if (dir_q) begin
            enc_d   = u8cm_encode(in_data_i.in_byte);
            idx_d   = '0;
            state_d = StEnc;
          end else begin
            buf_d[cnt_q[IdxW-1:0]] = in_data_i.in_byte;
            cnt_d   = cnt_q + 1'b1;
            code_d  = '0;
            part_d  = 1'b0;
            state_d = StScan;
          end
        end
      end
      StEnc: begin
        if (out_free) begin
          ovalid_d          = 1'b1;
          odata_d.out_byte  = enc_q.b[idx_q];
          odata_d.out_last  = last_q && (idx_q == 3'(enc_q.len - 3'd1));
          idx_d             = idx_q + 3'd1;
          if (idx_q == 3'(enc_q.len - 3'd1)) state_d = StIdle;
        end
      end
      StScan: begin
        part_d = part_q || part_hit;
        code_d = code_q + 8'd1;
        if (full_hit) begin
          emit_d  = code_q;
          shift_d = ent.len;
          state_d = StEmit;
        end else if (code_q == 8'hff) begin
          if ((part_q || part_hit) && !last_q) begin
            state_d = StIdle;
          end else begin
            emit_d  = buf_q[0];
            shift_d = 3'd1;
            state_d = StEmit;
          end
        end
      end
      StEmit: begin
        if (out_free) begin
          ovalid_d         = 1'b1;
          odata_d.out_byte = emit_q;
          odata_d.out_last = last_q && (cnt_rem == '0);
          for (int i = 0; i < int'(MaxSeqBytes); i++) begin
            for (int s = 1; s <= int'(ENC_BYTES); s++) begin
              if ((int'(shift_q) == s) && (i + s < int'(MaxSeqBytes))) begin
                buf_d[i] = buf_q[i+s];
              end
            end
          end
          cnt_d  = cnt_rem;
          code_d = '0;
          part_d = 1'b0;
          state_d = (cnt_rem == '0) ? StIdle : StScan;
        end
      end
      default: state_d = StIdle;
    endcase

    // Configuration must be written only while idle, unchecked; it drops held bytes.
    if (cfg_we_i) cnt_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      dir_q    <= 1'b0;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
      if (cfg_we_i) dir_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q  <= last_d;
    buf_q   <= buf_d;
    code_q  <= code_d;
    part_q  <= part_d;
    emit_q  <= emit_d;
    shift_q <= shift_d;
    enc_q   <= enc_d;
    idx_q   <= idx_d;
    odata_q <= odata_d;
  end

endmodule

>>> src/u8cm_checker.sv
module u8cm_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input u8cm_pkg::u8cm_out_t out_data_o
);

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input still ready after a word was taken");

  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o && !in_valid_i |=> in_ready_o)
    else $error("block left idle without an input word");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output word changed");

endmodule

bind utf8_charmap_transcoder u8cm_checker u_u8cm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

>>> tb/sv/utf8_charmap_checker.sv
`timescale 1ns / 1ps

module utf8_charmap_checker
  import u8cm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  u8cm_in_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  u8cm_out_t out_data_i,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  output int        fail_count_o,
  output int        pending_words_o,
  output int        checked_words_o
);

  localparam int unsigned SEL = 32'h0100_0000;  // glyph is followed by U+FE0F

  localparam int unsigned GLYPH_LOW [32] = '{
    'h0000, 'h00B9, 'h00B2, 'h00B3, 'h2074, 'h2075, 'h2076, 'h2077,
    'h2078, 'h0009, 'h000A, 'h1D47, 'h1D9C, 'h000D, 'h1D49, 'h1DA0,
    'h25AE, 'h25A0, 'h25A1, 'h2059, 'h2058, 'h2016, 'h25C0, 'h25B6,
    'h300C, 'h300D, 'h00A5, 'h2022, 'h3001, 'h3002, 'h309B, 'h309C
  };

  localparam int unsigned GLYPH_HIGH [129] = '{
    'h25CB,
    'h2588, 'h2592, 'h1F431, 'h2B07 | SEL, 'h2591, 'h273D, 'h25CF, 'h2665,
    'h2609, 'hC6C3, 'h2302, 'h2B05 | SEL, 'h1F610, 'h266A, 'h1F17E | SEL, 'h25C6,
    'h2026, 'h27A1 | SEL, 'h2605, 'h29D7, 'h2B06 | SEL, 'h02C7, 'h2227, 'h274E,
    'h25A4, 'h25A5, 'h3042, 'h3044, 'h3046, 'h3048, 'h304A, 'h304B,
    'h304D, 'h304F, 'h3051, 'h3053, 'h3055, 'h3057, 'h3059, 'h305B,
    'h305D, 'h305F, 'h3061, 'h3064, 'h3066, 'h3068, 'h306A, 'h306B,
    'h306C, 'h306D, 'h306E, 'h306F, 'h3072, 'h3075, 'h3078, 'h307B,
    'h307E, 'h307F, 'h3080, 'h3081, 'h3082, 'h3084, 'h3086, 'h3088,
    'h3089, 'h308A, 'h308B, 'h308C, 'h308D, 'h308F, 'h3092, 'h3093,
    'h3063, 'h3083, 'h3085, 'h3087, 'h30A2, 'h30A4, 'h30A6, 'h30A8,
    'h30AA, 'h30AB, 'h30AD, 'h30AF, 'h30B1, 'h30B3, 'h30B5, 'h30B7,
    'h30B9, 'h30BB, 'h30BD, 'h30BF, 'h30C1, 'h30C4, 'h30C6, 'h30C8,
    'h30CA, 'h30CB, 'h30CC, 'h30CD, 'h30CE, 'h30CF, 'h30D2, 'h30D5,
    'h30D8, 'h30DB, 'h30DE, 'h30DF, 'h30E0, 'h30E1, 'h30E2, 'h30E4,
    'h30E6, 'h30E8, 'h30E9, 'h30EA, 'h30EB, 'h30EC, 'h30ED, 'h30EF,
    'h30F2, 'h30F3, 'h30C3, 'h30E3, 'h30E5, 'h30E7, 'h25DC, 'h25DD
  };

  int         glyph_len [256];
  logic [7:0] glyph_seq [256][8];

  logic       to_utf8;
  logic [7:0] held [6];
  int         held_n;
  u8cm_out_t  expected_q [$];

  function automatic void append_cp(input int unsigned cp, input int c);
    int n;
    n = glyph_len[c];
    if (cp < 'h80) begin
      glyph_seq[c][n] = cp[7:0];
      n += 1;
    end else if (cp < 'h800) begin
      glyph_seq[c][n]   = 8'hC0 | 8'(cp >> 6);
      glyph_seq[c][n+1] = 8'h80 | 8'(cp & 'h3F);
      n += 2;
    end else if (cp < 'h10000) begin
      glyph_seq[c][n]   = 8'hE0 | 8'(cp >> 12);
      glyph_seq[c][n+1] = 8'h80 | 8'((cp >> 6) & 'h3F);
      glyph_seq[c][n+2] = 8'h80 | 8'(cp & 'h3F);
      n += 3;
    end else begin
      glyph_seq[c][n]   = 8'hF0 | 8'((cp >> 18) & 'h07);
      glyph_seq[c][n+1] = 8'h80 | 8'((cp >> 12) & 'h3F);
      glyph_seq[c][n+2] = 8'h80 | 8'((cp >> 6) & 'h3F);
      glyph_seq[c][n+3] = 8'h80 | 8'(cp & 'h3F);
      n += 4;
    end
    glyph_len[c] = n;
  endfunction

  initial begin
    int unsigned g;
    for (int c = 0; c < 256; c++) begin
      if (c < 32) g = GLYPH_LOW[c];
      else if (c < 'h7F) g = c;
      else g = GLYPH_HIGH[c - 'h7F];
      glyph_len[c] = 0;
      append_cp(g & 'h1F_FFFF, c);
      if ((g & SEL) != 0) append_cp('hFE0F, c);
    end
  end

  // Lets the stimulus build well-formed UTF-8 for a code.
  function automatic int code_len(input int c);
    return glyph_len[c];
  endfunction

  function automatic logic [7:0] code_byte(input int c, input int i);
    return glyph_seq[c][i];
  endfunction

  task automatic transcode_word(input u8cm_in_t w);
    logic [7:0] seq [8];
    int         n;
    int         hit;
    int         hit_len;
    int         span;
    int         added;
    bit         partial;
    bit         same;
    u8cm_out_t  r;
    added = 0;
    if (to_utf8) begin
      for (int i = 0; i < glyph_len[w.in_byte]; i++) begin
        expected_q.push_back('{out_byte: glyph_seq[w.in_byte][i], out_last: 1'b0});
        added++;
      end
    end else begin
      n = held_n;
      for (int i = 0; i < n; i++) seq[i] = held[i];
      seq[n] = w.in_byte;
      n++;
      while (n > 0) begin
        hit = -1;
        hit_len = 0;
        partial = 0;
        for (int c = 0; c < 256 && hit < 0; c++) begin
          if (glyph_len[c] >= 2) begin
            span = (glyph_len[c] <= n) ? glyph_len[c] : n;
            same = 1;
            for (int i = 0; i < span; i++) if (glyph_seq[c][i] != seq[i]) same = 0;
            if (same && glyph_len[c] <= n) begin
              hit = c;
              hit_len = glyph_len[c];
            end else if (same) begin
              partial = 1;
            end
          end
        end
        if (hit < 0 && partial && !w.in_last) break;
        // A full match gives the code; otherwise the oldest byte goes out raw.
        if (hit >= 0) begin
          r = '{out_byte: 8'(hit), out_last: 1'b0};
        end else begin
          r = '{out_byte: seq[0], out_last: 1'b0};
          hit_len = 1;
        end
        expected_q.push_back(r);
        added++;
        for (int i = 0; i + hit_len < n; i++) seq[i] = seq[i + hit_len];
        n -= hit_len;
      end
      held_n = n;
      for (int i = 0; i < n; i++) held[i] = seq[i];
    end
    if (w.in_last && added > 0) expected_q[expected_q.size() - 1].out_last = 1'b1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    u8cm_out_t want;
    if (!rst_ni) begin
      to_utf8 = 1'b0;
      held_n = 0;
      expected_q.delete();
      fail_count_o = 0;
      checked_words_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("unexpected output word %h last %b", out_data_i.out_byte,
                     out_data_i.out_last);
        end else begin
          want = expected_q.pop_front();
          checked_words_o++;
          if (out_data_i.out_byte !== want.out_byte || out_data_i.out_last !== want.out_last) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("output mismatch: expected %h last %b, got %h last %b",
                       want.out_byte, want.out_last, out_data_i.out_byte, out_data_i.out_last);
          end
        end
      end
      if (in_valid_i && in_ready_i) transcode_word(in_data_i);
      if (cfg_we_i) begin
        to_utf8 = cfg_wdata_i;
        held_n = 0;
      end
    end
    pending_words_o = expected_q.size();
  end

endmodule

>>> tb/sv/tb_utf8_charmap_transcoder.sv
`timescale 1ns / 1ps

module tb_utf8_charmap_transcoder;
  import u8cm_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  u8cm_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  u8cm_out_t out_data;
  logic      cfg_we = 1'b0;
  logic      cfg_wdata = 1'b0;

  int fail_count;
  int pending_words;
  int checked_words;
  int words_sent = 0;

  // Set by the stimulus to make the receiver hold off for a long stretch.
  bit long_hold = 0;
  // When set, both sides run without idle gaps.
  bit no_gaps = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  utf8_charmap_transcoder DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  utf8_charmap_checker chk (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .in_data_i      (in_data),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .out_data_i     (out_data),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .fail_count_o   (fail_count),
    .pending_words_o(pending_words),
    .checked_words_o(checked_words)
  );

  // Draws an idle gap for either side. About half of the draws are zero so that
  // back-to-back stretches show up alongside the gappy ones.
  function automatic int idle_cycles();
    if (no_gaps || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, 14);
  endfunction

  // Receiver. The long hold is counted here so the sender keeps offering words
  // and the block backs up into its input.
  initial begin
    int k;
    @(posedge rst_n);
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        long_hold = 0;
      end
      k = idle_cycles();
      if (k > 0) begin
        out_ready <= 1'b0;
        repeat (k) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // Offers one word; valid stays up into the next word when there is no gap.
  task automatic send_word(input logic [7:0] b, input logic last);
    int k;
    k = idle_cycles();
    if (k > 0) begin
      in_valid <= 1'b0;
      repeat (k) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{in_byte: b, in_last: last};
    do @(posedge clk); while (!(in_valid && in_ready));
    words_sent++;
  endtask

  // Sends the UTF-8 form of a code; the last byte carries the end mark.
  task automatic send_code(input int c, input logic last);
    int n;
    n = chk.code_len(c);
    for (int i = 0; i < n; i++) send_word(chk.code_byte(c, i), last && (i == n - 1));
  endtask

  // Waits until every expected word is out. A decode scan over the whole table
  // can run without producing anything, so the tail covers a few full passes.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
    repeat (2000) @(posedge clk);
  endtask

  task automatic set_direction(input logic d);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Random decode traffic: mostly well-formed glyphs, with truncated
  // sequences and raw noise bytes mixed in.
  task automatic decode_traffic(input int count);
    int sel;
    int c;
    int n;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 19);
      c = $urandom_range(0, 255);
      if (sel < 13) begin
        send_code(c, $urandom_range(0, 5) == 0);
      end else if (sel < 16) begin
        n = chk.code_len(c);
        n = (n > 1) ? $urandom_range(1, n - 1) : 1;
        for (int j = 0; j < n; j++) send_word(chk.code_byte(c, j), 1'b0);
      end else begin
        send_word(8'($urandom), $urandom_range(0, 3) == 0);
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Decode, directed: plain ASCII, three and four byte glyphs, a
    // mismatch that forces a rescan, a flush of a held prefix, raw extremes.
    send_word(8'h41, 1'b1);
    send_code('h80, 1'b1);
    send_code('h82, 1'b0);
    send_code('h8F, 1'b1);
    send_code('hFF, 1'b0);
    send_word(8'hE2, 1'b0);
    send_word(8'h97, 1'b0);
    send_word(8'h41, 1'b0);
    send_word(8'hE2, 1'b0);
    send_word(8'h97, 1'b1);
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b1);
    send_word(8'h80, 1'b0);
    // A held prefix is dropped by the direction write.
    send_word(8'hE2, 1'b0);

    set_direction(1'b1);
    // Encode, directed: both ends of the code range and the map boundaries.
    send_word(8'h00, 1'b0);
    send_word(8'h09, 1'b0);
    send_word(8'h1F, 1'b0);
    send_word(8'h7E, 1'b0);
    send_word(8'h7F, 1'b0);
    send_word(8'h8F, 1'b0);
    send_word(8'hFF, 1'b1);

    set_direction(1'b0);
    decode_traffic(30);

    // Back-pressure: the receiver stalls while the sender keeps going.
    no_gaps = 1;
    long_hold = 1;
    decode_traffic(10);
    no_gaps = 0;
    // The sender waits for the block to catch up completely.
    drain();
    decode_traffic(15);

    set_direction(1'b1);
    for (int i = 0; i < 30; i++) send_word(8'($urandom), $urandom_range(0, 4) == 0);

    set_direction(1'b0);
    decode_traffic(10);
    drain();

    $display("Sent %0d input words over both directions and checked %0d output words,",
             words_sent, checked_words);
    $display("including rescans, end flushes and a long output stall.");
    if (fail_count == 0) begin
      $display("utf8_charmap_transcoder verification clean");
    end else begin
      $display("utf8_charmap_transcoder verification failed");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("utf8_charmap_transcoder verification failed");
    $finish;
  end

endmodule

>>> filelist.f
src/u8cm_pkg.sv
src/utf8_charmap_transcoder.sv
src/u8cm_checker.sv
tb/sv/utf8_charmap_checker.sv
tb/sv/tb_utf8_charmap_transcoder.sv
